// File: rtl/core/ss_pkg.sv
// Package for the substring search unit: register codes, field widths and
// the control group that the top level hands to the match cells.
// Depends on nothing.
package ss_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam longint TEXT_MAX_DEF = 65536;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 5;
    localparam int OFFSET_W   = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int BYTES_PER_WORD = CFG_DATA_W / BYTE_W;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd2;

    // Per-cycle control shared by every cell of the chain.
    typedef struct packed {
        logic advance;
        logic clear;
    } ss_ctrl_t;

endpackage

// File: rtl/core/ss_if.sv
// Channel interfaces of the substring search unit: text bytes in and
// search results out, each with a valid/ready handshake.
// Depends on ss_pkg.
interface ss_text_if;
    logic                      valid;
    logic                      ready;
    logic [ss_pkg::BYTE_W-1:0] text_byte;
    logic                      last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

interface ss_result_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [ss_pkg::OFFSET_W-1:0] match_offset;
    logic                        length_overflow;

    modport source (output valid, output found, output match_offset,
                    output length_overflow, input ready);
    modport sink (input valid, input found, input match_offset,
                  input length_overflow, output ready);
endinterface

// File: rtl/core/ss_cell.sv
// One cell of the shift-and chain: holds one pattern byte and one
// partial-match bit, and passes the bit to its right-hand neighbor.
// Depends on ss_pkg.
module ss_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ss_pkg::ss_ctrl_t          ctrl,
    input  logic                      pat_we,
    input  logic [ss_pkg::BYTE_W-1:0] pat_data,
    input  logic [ss_pkg::BYTE_W-1:0] text_byte,
    input  logic                      prev_bit,
    output logic                      match_next,
    output logic                      match_bit
);

    logic [ss_pkg::BYTE_W-1:0] pat_reg;
    logic                      bit_reg;
    logic                      bit_next;

    // The bit after this byte: the neighbor matched up to here and this
    // cell's pattern byte equals the incoming text byte.
    assign match_next = prev_bit && (pat_reg == text_byte);
    assign bit_next   = ctrl.clear ? 1'b0 : match_next;
    assign match_bit  = bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg <= '0;
            bit_reg <= 1'b0;
        end
        else
        begin
            if (pat_we)
            begin
                pat_reg <= pat_data;
            end
            if (ctrl.advance)
            begin
                bit_reg <= bit_next;
            end
        end
    end

endmodule

// File: rtl/core/substring_search_unit.sv
// Top level of the substring search unit: configuration registers, the
// chain of match cells, the byte counter and the result register.
// Depends on ss_pkg, ss_if and ss_cell.
//
//   Port       Dir   Handshake     Payload
//   text       in    valid/ready   text_byte, last_byte
//   result     out   valid/ready   found, match_offset, length_overflow
//   cfg_*      in    write enable  cfg_index, cfg_data
//
// One text byte is taken per cycle while input ready is high; the chain of
// cells updates every partial-match bit in that same cycle.
// The result appears in the cycle after the transaction that carries the
// last byte and sits in an output register until it is taken.
// Input ready drops only while that register is full and not being taken.
// Reset clears the registers, the pattern and all search state at once.
module substring_search_unit #(
    parameter int     PATTERN_MAX = ss_pkg::PATTERN_MAX_DEF,
    parameter longint TEXT_MAX    = ss_pkg::TEXT_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ss_pkg::CFG_DATA_W-1:0] cfg_data,
    ss_text_if.sink                       text,
    ss_result_if.source                   result
);

    localparam int POS_W = $clog2(TEXT_MAX + 1);
    localparam int SUM_W = (POS_W > ss_pkg::OFFSET_W) ? POS_W : ss_pkg::OFFSET_W;
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(TEXT_MAX);

    logic [ss_pkg::LEN_W-1:0]    len_reg;
    logic [POS_W-1:0]            pos_reg;
    logic [POS_W-1:0]            pos_next;
    logic                        seen_reg;
    logic                        seen_next;
    logic [ss_pkg::OFFSET_W-1:0] offset_reg;
    logic [ss_pkg::OFFSET_W-1:0] offset_next;
    logic                        out_valid_reg;
    logic                        out_found_reg;
    logic [ss_pkg::OFFSET_W-1:0] out_offset_reg;
    logic                        out_ovf_reg;

    logic                        len_we;
    logic                        low_we;
    logic                        high_we;
    logic                        text_acc;
    logic                        in_range;
    logic                        hit;
    logic [SUM_W-1:0]            start_sum;
    logic [PATTERN_MAX-1:0]      len_onehot;
    logic [PATTERN_MAX-1:0]      chain_next;
    logic [PATTERN_MAX-1:0]      chain_bits;
    ss_pkg::ss_ctrl_t            ctrl;

    always_comb
    begin
        len_we  = 1'b0;
        low_we  = 1'b0;
        high_we = 1'b0;
        unique case (cfg_index)
            ss_pkg::REG_PATTERN_LENGTH: len_we  = cfg_we;
            ss_pkg::REG_PATTERN_LOW:    low_we  = cfg_we;
            ss_pkg::REG_PATTERN_HIGH:   high_we = cfg_we;
            default:                    len_we  = 1'b0;
        endcase
    end

    assign text.ready   = !out_valid_reg || result.ready;
    assign text_acc     = text.valid && text.ready;
    assign ctrl.advance = text_acc;
    assign ctrl.clear   = text.last_byte;

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            logic pat_we;
            logic prev_bit;

            if (k < ss_pkg::BYTES_PER_WORD)
            begin : g_low
                assign pat_we = low_we;
            end
            else
            begin : g_high
                assign pat_we = high_we;
            end

            if (k == 0)
            begin : g_head
                assign prev_bit = 1'b1;
            end
            else
            begin : g_link
                assign prev_bit = chain_bits[k-1];
            end

            assign len_onehot[k] = (len_reg == ss_pkg::LEN_W'(k + 1));

            ss_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .pat_we     (pat_we),
                .pat_data   (cfg_data[ss_pkg::BYTE_W*(k % ss_pkg::BYTES_PER_WORD) +:
                                      ss_pkg::BYTE_W]),
                .text_byte  (text.text_byte),
                .prev_bit   (prev_bit),
                .match_next (chain_next[k]),
                .match_bit  (chain_bits[k])
            );
        end
    endgenerate

    // A length of zero or beyond the chain selects no cell and never hits.
    assign in_range  = (pos_reg < POS_LIMIT);
    assign hit       = in_range && !seen_reg && |(chain_next & len_onehot);
    assign start_sum = SUM_W'(pos_reg) + SUM_W'(1) - SUM_W'(len_reg);

    always_comb
    begin
        seen_next   = seen_reg;
        offset_next = offset_reg;
        pos_next    = pos_reg;
        if (hit)
        begin
            seen_next   = 1'b1;
            offset_next = start_sum[ss_pkg::OFFSET_W-1:0];
        end
        if (in_range)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg        <= '0;
            pos_reg        <= '0;
            seen_reg       <= 1'b0;
            offset_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_found_reg  <= 1'b0;
            out_offset_reg <= '0;
            out_ovf_reg    <= 1'b0;
        end
        else
        begin
            if (len_we)
            begin
                len_reg <= cfg_data[ss_pkg::LEN_W-1:0];
            end
            if (text_acc && text.last_byte)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (text_acc)
            begin
                if (text.last_byte)
                begin
                    pos_reg        <= '0;
                    seen_reg       <= 1'b0;
                    offset_reg     <= '0;
                    out_found_reg  <= seen_next;
                    out_offset_reg <= seen_next ? offset_next : '0;
                    out_ovf_reg    <= !in_range;
                end
                else
                begin
                    pos_reg    <= pos_next;
                    seen_reg   <= seen_next;
                    offset_reg <= offset_next;
                end
            end
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.found           = out_found_reg;
    assign result.match_offset    = out_offset_reg;
    assign result.length_overflow = out_ovf_reg;

`ifndef ASSERT_OFF
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        text_acc && text.last_byte |=> pos_reg == '0 && !seen_reg && chain_bits == '0)
        else $error("search state not cleared after the last byte");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        text_acc && text.last_byte |=> result.valid)
        else $error("no result after the last byte");

    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.found |-> result.match_offset == '0)
        else $error("offset reported without a match");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LIMIT)
        else $error("byte counter passed its limit");
`endif

endmodule
